// ===== sv/tasg_pkg.sv =====
// Shared types, codes and the sine table builder of the test audio sample generator.
package tasg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = 12;
    localparam int LENGTH_W  = 13;
    localparam int PHASE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MAG_W     = 15;

    localparam logic [PHASE_W-1:0] DEFAULT_STEP = 32'h1000_0000;
    localparam logic [63:0]        HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
    localparam logic [MAG_W-1:0]   SINE_AMPL    = 15'd16384;

    // Input item actions.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Mode register codes.
    localparam logic [1:0] MODE_RAMP    = 2'd0;
    localparam logic [1:0] MODE_SINE    = 2'd1;
    localparam logic [1:0] MODE_BUFFER  = 2'd2;
    localparam logic [1:0] MODE_SILENCE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LENGTH = 2'd2;

    // Which source the output stage selects for a tick.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_RAMP,
        KIND_SINE,
        KIND_BUFFER
    } t_kind;

    // Bits [125:62] of the full product, i.e. (a*b) >> 62 in Q2.62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Restoring long division; only used while the sine table is built.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // trunc(16384 * sin(pi/2 * r / q)) by a truncating Taylor series; elaboration only.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned q,
                                                      input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] denom;
        if (r == 0) begin
            return '0;
        end
        if (r >= q) begin
            return SINE_AMPL;
        end
        x = (HALF_PI_Q62 >> (tbits - 2)) * 64'(r);
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 15; n++) begin
            denom = 64'(2 * n) * 64'(2 * n + 1);
            term = div_u64(mul_q62(term, x2), denom);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum[62:48];
    endfunction

endpackage

// ===== sv/tasg_sine_rom.sv =====
// Quarter-wave sine magnitude table with a registered read port.
module tasg_sine_rom
    import tasg_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [TABLE_BITS-2:0]   i_idx,
    output logic [MAG_W-1:0]        o_mag
);

    localparam int QUARTER = 1 << (TABLE_BITS - 2);

    typedef logic [MAG_W-1:0] t_rom [QUARTER+1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= QUARTER; i++) begin
            rom[i] = quarter_sine(i, QUARTER, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= SINE_ROM[i_idx];
        end
    end

    assign o_mag = r_mag;

endmodule

// ===== sv/test_audio_sample_generator_core.sv =====
// Top level of the test audio sample generator: counters, sample store and output stage.
//
// Usage. Items arrive on i_valid/o_ready with i_action, i_address and i_sample_in.
// A tick item gives one sample on o_valid/i_ready (o_sample); load and restart
// items give none. A load writes one entry of the sample store, a restart clears
// the ramp counter, the sine phase and the play position.
// Configuration is written on i_cfg_valid/o_cfg_ready (always ready) with
// i_cfg_index (0 mode, 1 phase step, 2 buffer length) and i_cfg_data. The user
// must write it only while the block is idle; the block does not enforce this.
// Writing the buffer length clears the play position. A tick's sample is offered
// once it has passed the synchronous store read and the sine table read, then the
// output register. Throughput is one item per cycle while o_ready is high; the
// counters update in the accept cycle and a load is visible to a tick accepted in
// the next cycle. When the receiver stalls, the output register holds its sample,
// the middle stage fills, and o_ready drops until the output moves again.
// Reset clears the registers to mode ramp, default phase step, empty buffer, and
// zero counters. The store contents are undefined until loaded.
module test_audio_sample_generator_core
    import tasg_pkg::*;
#(
    parameter int STORE_DEPTH     = 4096,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [ADDR_W-1:0]           i_address,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int POS_W   = $clog2(STORE_DEPTH);
    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam logic [SINE_TABLE_BITS-2:0] QUARTER_IDX = (SINE_TABLE_BITS-1)'(QUARTER);

    // Configuration registers.
    logic [1:0]          r_mode;
    logic [PHASE_W-1:0]  r_step;
    logic [LENGTH_W-1:0] r_buf_len;

    // Generator state.
    logic [31:0]         r_count, n_count;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;

    // Middle stage and output register.
    logic                       r_s1_valid;
    t_kind                      r_s1_kind;
    logic [SAMPLE_W-1:0]        r_s1_ramp;
    logic                       r_s1_neg;
    logic [SAMPLE_W-1:0]        r_rd_data;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic                   w_accept, w_tick, w_load, w_restart, w_advance;
    t_kind                  w_kind;
    logic [LENGTH_W-1:0]    w_len;
    logic [POS_W-1:0]       w_rd_pos;
    logic [POS_W-1:0]       w_pos_inc;
    logic [31:0]            w_addr_ext;
    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [1:0]             w_quad;
    logic [SINE_TABLE_BITS-2:0] w_r_ext;
    logic [SINE_TABLE_BITS-2:0] w_qidx;
    logic [MAG_W-1:0]       w_mag;
    logic [SAMPLE_W-1:0]    w_s1_sample;

    assign w_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_advance;
    assign w_accept  = i_valid && o_ready;
    assign w_tick    = w_accept && (i_action == ACT_TICK);
    assign w_load    = w_accept && (i_action == ACT_LOAD);
    assign w_restart = w_accept && (i_action == ACT_RESTART);

    assign o_cfg_ready = 1'b1;

    // Length in use: the register, capped at the store depth.
    assign w_len = ({19'd0, r_buf_len} > 32'(STORE_DEPTH)) ? LENGTH_W'(STORE_DEPTH)
                                                          : r_buf_len;
    // A position left stale by a shorter length restarts at entry zero.
    assign w_rd_pos  = (32'(r_pos) >= 32'(w_len)) ? '0 : r_pos;
    assign w_pos_inc = w_rd_pos + POS_W'(1);

    assign w_addr_ext = 32'(i_address);

    // Sine table address folded into the first quadrant.
    assign w_k     = r_phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_quad  = w_k[SINE_TABLE_BITS-1 -: 2];
    assign w_r_ext = {1'b0, w_k[SINE_TABLE_BITS-3:0]};
    assign w_qidx  = w_quad[0] ? (QUARTER_IDX - w_r_ext) : w_r_ext;

    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        n_pos   = r_pos;
        w_kind  = KIND_ZERO;
        case (r_mode)
            MODE_RAMP, MODE_SINE: begin
                w_kind = (r_mode == MODE_RAMP) ? KIND_RAMP : KIND_SINE;
                if (w_tick) begin
                    n_count = r_count + 32'd1;
                    n_phase = r_phase + ((r_step != '0) ? r_step : DEFAULT_STEP);
                end
            end
            MODE_BUFFER: begin
                if (w_len != '0) begin
                    w_kind = KIND_BUFFER;
                    if (w_tick) begin
                        n_pos = (32'(w_pos_inc) >= 32'(w_len)) ? '0 : w_pos_inc;
                    end
                end
            end
            default: begin
                w_kind = KIND_ZERO;
            end
        endcase
        if (w_restart) begin
            n_count = '0;
            n_phase = '0;
            n_pos   = '0;
        end
        // A new buffer length restarts playback from entry zero.
        if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_BUF_LENGTH)) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RAMP;
            r_step      <= DEFAULT_STEP;
            r_buf_len   <= '0;
            r_count     <= '0;
            r_phase     <= '0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:       r_mode <= i_cfg_data[1:0];
                    CFG_PHASE_STEP: r_step <= i_cfg_data;
                    CFG_BUF_LENGTH: begin
                        r_buf_len <= i_cfg_data[LENGTH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_tick) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payload, captured with the tick that fills the stage.
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_kind <= w_kind;
            r_s1_ramp <= r_count[SAMPLE_W-1:0];
            r_s1_neg  <= w_quad[1];
        end
        if (w_advance) begin
            r_out_sample <= w_s1_sample;
        end
    end

    // Sample store: written by loads, read at the accept edge of every tick.
    always_ff @(posedge i_clk) begin
        if (w_load && (w_addr_ext < 32'(STORE_DEPTH))) begin
            mem[w_addr_ext[POS_W-1:0]] <= i_sample_in;
        end
        if (w_tick) begin
            r_rd_data <= mem[w_rd_pos];
        end
    end

    tasg_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk (i_clk),
        .i_en  (w_tick),
        .i_idx (w_qidx),
        .o_mag (w_mag)
    );

    always_comb begin
        case (r_s1_kind)
            KIND_RAMP:   w_s1_sample = r_s1_ramp;
            KIND_SINE:   w_s1_sample = r_s1_neg ? (SAMPLE_W'(0) - SAMPLE_W'(w_mag))
                                                : SAMPLE_W'(w_mag);
            KIND_BUFFER: w_s1_sample = r_rd_data;
            default:     w_s1_sample = '0;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_restart |=> (r_count == '0) && (r_phase == '0) && (r_pos == '0))
        else $error("restart did not clear the generator state");

    a_ramp_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && (r_mode == MODE_RAMP)) |=> (r_count == $past(r_count) + 32'd1))
        else $error("ramp tick did not advance the counter");

    a_tick_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_s1_valid)
        else $error("accepted tick did not reach the middle stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |=> (r_s1_valid && $stable(r_s1_kind)))
        else $error("middle stage lost its item during an output stall");

    a_pos_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < 32'(STORE_DEPTH))
        else $error("play position left the store");

endmodule

// ===== tb/tb_test_audio_sample_generator_core.sv =====
// Self-checking testbench for the test audio sample generator core.
`timescale 1ns / 1ps

module tb_test_audio_sample_generator_core;
    import tasg_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int SINE_BITS   = 10;
    localparam int LUT_SIZE    = 1 << SINE_BITS;
    localparam int QUARTER     = LUT_SIZE / 4;
    localparam int MAX_CYCLES  = 400_000;
    localparam int PHASE_ITEMS = 110;
    localparam int RANDOM_PHASES = 14;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [ADDR_W-1:0]   address;
        logic [SAMPLE_W-1:0] value;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic [1:0] i_action;
    logic [ADDR_W-1:0] i_address;
    logic signed [SAMPLE_W-1:0] i_sample_in;
    logic o_valid;
    logic i_ready;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    test_audio_sample_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_address   (i_address),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted state of the generator.
    logic [1:0]          cfg_mode;
    logic [PHASE_W-1:0]  cfg_step;
    logic [LENGTH_W-1:0] cfg_len;
    logic [31:0]         ramp_count;
    logic [PHASE_W-1:0]  phase_acc;
    int unsigned         play_pos;
    logic [SAMPLE_W-1:0] sample_mem [0:STORE_DEPTH-1];
    logic signed [SAMPLE_W-1:0] sine_lut [0:LUT_SIZE-1];

    // Stimulus side: which store entries have been loaded and where playback will read.
    bit          gen_written [0:STORE_DEPTH-1];
    int unsigned gen_pos;

    t_request request_fifo [$];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    t_request req_now;

    bit taken;
    bit delivered;
    int unsigned send_wait;
    int unsigned stall_left;
    bit tx_calm;
    bit rx_calm;
    int unsigned fail_count;
    int unsigned cycle_count;

    // (a*b) >> 62 of two Q2.62 numbers.
    function automatic logic [63:0] fixmul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[125:62];
    endfunction

    // Magnitude of one quarter-wave point: truncated odd Taylor series of sin.
    function automatic int unsigned taylor_quarter(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        if (r == 0) begin
            return 0;
        end
        if (r >= QUARTER) begin
            return 16384;
        end
        x = (HALF_PI_Q62 >> (SINE_BITS - 2)) * 64'(r);
        x2 = fixmul62(x, x);
        term = x;
        acc = x;
        for (int n = 1; n <= 15; n++) begin
            term = fixmul62(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return int'(acc >> 48);
    endfunction

    function automatic int unsigned pick_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic apply_request(input t_request rq);
        logic signed [SAMPLE_W-1:0] s;
        int unsigned eff;
        s = '0;
        case (rq.action)
            ACT_LOAD: begin
                sample_mem[rq.address] = rq.value;
            end
            ACT_RESTART: begin
                ramp_count = '0;
                phase_acc = '0;
                play_pos = 0;
            end
            ACT_TICK: begin
                if (cfg_mode == MODE_RAMP || cfg_mode == MODE_SINE) begin
                    s = (cfg_mode == MODE_RAMP) ? ramp_count[15:0]
                                                : sine_lut[phase_acc[PHASE_W-1 -: SINE_BITS]];
                    ramp_count = ramp_count + 1;
                    phase_acc = phase_acc + ((cfg_step != 0) ? cfg_step : DEFAULT_STEP);
                end else if (cfg_mode == MODE_BUFFER) begin
                    eff = (cfg_len > STORE_DEPTH) ? STORE_DEPTH : cfg_len;
                    if (eff != 0) begin
                        if (play_pos >= eff) begin
                            play_pos = 0;
                        end
                        s = sample_mem[play_pos];
                        play_pos++;
                        if (play_pos >= eff) begin
                            play_pos = 0;
                        end
                    end
                end
                expected_samples.push_back(s);
            end
            default: begin
            end
        endcase
    endtask

    // Accepts input items and checks results, both sampled at the rising edge.
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        taken = i_rst_n && i_valid && o_ready;
        delivered = i_rst_n && o_valid && i_ready;
        if (taken) begin
            apply_request(req_now);
        end
        if (delivered) begin
            if (expected_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("sample with none expected: got %0d", o_sample);
                end
            end else begin
                want = expected_samples.pop_front();
                if (o_sample !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("sample mismatch: expected %0d, got %0d", want, o_sample);
                    end
                end
            end
        end
    end

    // Sender: holds each item until accepted, then waits its drawn gap.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || taken)) begin
            if (send_wait > 0) begin
                i_valid <= 1'b0;
                send_wait--;
            end else if (request_fifo.size() > 0) begin
                req_now = request_fifo.pop_front();
                i_valid <= 1'b1;
                i_action <= req_now.action;
                i_address <= req_now.address;
                i_sample_in <= req_now.value;
                send_wait = pick_wait(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls a drawn number of cycles before taking each result.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (delivered) begin
                stall_left = pick_wait(rx_calm);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                if (o_valid) begin
                    stall_left--;
                end
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("test_audio_sample_generator_core verification failed");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (index)
            CFG_MODE: cfg_mode = data[1:0];
            CFG_PHASE_STEP: cfg_step = data;
            CFG_BUF_LENGTH: begin
                cfg_len = data[LENGTH_W-1:0];
                play_pos = 0;
                gen_pos = 0;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every item is taken and every sample is back, plus a tail.
    task automatic settle(input int tail);
        while (request_fifo.size() != 0 || i_valid || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic queue_request(input logic [1:0] act, input int unsigned addr,
                                 input logic [SAMPLE_W-1:0] val);
        t_request rq;
        rq.action = act;
        rq.address = addr[ADDR_W-1:0];
        rq.value = val;
        request_fifo.push_back(rq);
        if (act == ACT_LOAD) begin
            gen_written[addr[ADDR_W-1:0]] = 1'b1;
        end else if (act == ACT_RESTART) begin
            gen_pos = 0;
        end
    endtask

    // In buffer mode a tick must never read an entry that was never loaded,
    // so such an entry is loaded first.
    task automatic queue_tick();
        int unsigned eff;
        eff = (cfg_len > STORE_DEPTH) ? STORE_DEPTH : cfg_len;
        if (cfg_mode == MODE_BUFFER && eff != 0) begin
            if (gen_pos >= eff) begin
                gen_pos = 0;
            end
            if (!gen_written[gen_pos]) begin
                queue_request(ACT_LOAD, gen_pos, 16'($urandom));
            end
            gen_pos++;
            if (gen_pos >= eff) begin
                gen_pos = 0;
            end
        end
        queue_request(ACT_TICK, $urandom_range(0, STORE_DEPTH - 1), 16'($urandom));
    endtask

    task automatic fill_phase(input int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned eff;
        int unsigned addr;
        logic [SAMPLE_W-1:0] val;
        made = 0;
        eff = (cfg_len > STORE_DEPTH) ? STORE_DEPTH : cfg_len;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 74) begin
                queue_tick();
                made++;
            end else if (pick < 88) begin
                if (eff != 0 && $urandom_range(0, 1) == 1) begin
                    addr = $urandom_range(0, eff - 1);
                end else begin
                    addr = $urandom_range(0, STORE_DEPTH - 1);
                end
                case ($urandom_range(0, 5))
                    0: val = 16'h8000;
                    1: val = 16'h7FFF;
                    default: val = 16'($urandom);
                endcase
                queue_request(ACT_LOAD, addr, val);
                made++;
            end else if (pick < 95) begin
                queue_request(ACT_RESTART, $urandom_range(0, STORE_DEPTH - 1), 16'($urandom));
                made++;
            end else begin
                queue_request(ACT_UNUSED, $urandom_range(0, STORE_DEPTH - 1), 16'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned quad;
        int unsigned r;
        int sm;
        logic [1:0] mode_pick;
        logic [CFG_DATA_W-1:0] step_pick;
        logic [CFG_DATA_W-1:0] len_pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_TICK;
        i_address = '0;
        i_sample_in = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        taken = 1'b0;
        delivered = 1'b0;
        send_wait = 0;
        stall_left = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        gen_pos = 0;

        for (int k = 0; k < LUT_SIZE; k++) begin
            quad = k / QUARTER;
            r = k % QUARTER;
            sm = int'(taylor_quarter((quad % 2 == 1) ? QUARTER - r : r));
            sine_lut[k] = 16'((quad >= 2) ? -sm : sm);
        end

        cfg_mode = MODE_RAMP;
        cfg_step = DEFAULT_STEP;
        cfg_len = '0;
        ramp_count = '0;
        phase_acc = '0;
        play_pos = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ramp from reset, an ignored action, a restart, and loads at the address extremes.
        queue_tick();
        queue_tick();
        queue_request(ACT_UNUSED, STORE_DEPTH - 1, 16'hFFFF);
        queue_tick();
        queue_request(ACT_RESTART, 0, 16'h0000);
        queue_tick();
        queue_request(ACT_LOAD, STORE_DEPTH - 1, 16'h8000);
        queue_request(ACT_LOAD, 0, 16'h7FFF);
        queue_request(ACT_LOAD, 1, 16'hFFFF);
        settle(4);

        // A quarter-turn step lands on zero, both peaks and the negative zero.
        write_register(CFG_MODE, 32'(MODE_SINE));
        write_register(CFG_PHASE_STEP, 32'h4000_0000);
        queue_request(ACT_RESTART, 0, 16'h0000);
        repeat (4) queue_tick();
        settle(4);
        write_register(CFG_PHASE_STEP, 32'd0);
        repeat (2) queue_tick();
        settle(4);

        // Empty buffer, a two-entry loop, and a length beyond the store.
        write_register(CFG_MODE, 32'(MODE_BUFFER));
        queue_tick();
        settle(4);
        write_register(CFG_BUF_LENGTH, 32'd2);
        repeat (3) queue_tick();
        settle(4);
        write_register(CFG_BUF_LENGTH, 32'd8191);
        queue_request(ACT_RESTART, 0, 16'h0000);
        queue_tick();
        settle(4);

        // Silence must not advance the ramp counter.
        write_register(CFG_MODE, 32'(MODE_SILENCE));
        queue_tick();
        settle(4);
        write_register(CFG_MODE, 32'(MODE_RAMP));
        queue_tick();
        settle(4);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_register(CFG_MODE, 32'(MODE_SINE));
                    write_register(CFG_PHASE_STEP, 32'hFFFF_FFFF);
                    write_register(CFG_BUF_LENGTH, 32'd4096);
                end
                1: begin
                    write_register(CFG_MODE, 32'(MODE_BUFFER));
                    write_register(CFG_PHASE_STEP, 32'd1);
                    write_register(CFG_BUF_LENGTH, 32'd8191);
                end
                2: begin
                    write_register(CFG_BUF_LENGTH, 32'd1);
                end
                3: begin
                    write_register(CFG_MODE, 32'(MODE_SINE));
                    write_register(CFG_PHASE_STEP, 32'h8000_0000);
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1: mode_pick = MODE_RAMP;
                        2, 3, 4: mode_pick = MODE_SINE;
                        9: mode_pick = MODE_SILENCE;
                        default: mode_pick = MODE_BUFFER;
                    endcase
                    write_register(CFG_MODE, 32'(mode_pick));
                    if ($urandom_range(0, 2) != 0) begin
                        case ($urandom_range(0, 5))
                            0: step_pick = 32'd0;
                            1: step_pick = 32'hFFFF_FFFF;
                            default: step_pick = $urandom;
                        endcase
                        write_register(CFG_PHASE_STEP, step_pick);
                    end
                    if ($urandom_range(0, 9) < 7) begin
                        case ($urandom_range(0, 9))
                            0: len_pick = 32'd0;
                            1: len_pick = 32'd4096;
                            2: len_pick = $urandom_range(4097, 8191);
                            3, 4, 5: len_pick = $urandom_range(1, 8);
                            default: len_pick = $urandom_range(9, 300);
                        endcase
                        write_register(CFG_BUF_LENGTH, len_pick);
                    end
                end
            endcase
            fill_phase(PHASE_ITEMS);
            settle(4);
        end

        settle(12);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("test_audio_sample_generator_core verification clean");
        end else begin
            $display("test_audio_sample_generator_core verification failed");
        end
        $finish;
    end

endmodule
